// ===== src/nss_pkg.sv =====
// Shared types, constants and helpers for the automaton state-set stepper.
// No dependencies; the other files that use this package refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package nss_pkg;

   localparam int SET_W   = 64;
   localparam int STATE_W = 6;
   localparam int ENTRY_W = 2 * STATE_W;
   localparam int ACT_W   = 7;

   typedef enum logic [2:0] {
      MODE_WRITE_TRANS = 3'd0,
      MODE_WRITE_COUNT = 3'd1,
      MODE_LOAD_SET    = 3'd2,
      MODE_SYMBOL_STEP = 3'd3,
      MODE_CLOSURE     = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   // One transition as held in the table: source in the upper half.
   typedef struct packed {
      logic [STATE_W-1:0] src;
      logic [STATE_W-1:0] dst;
   } entry_type;

   // Ones in the lowest n bits, all ones for n of 64 or more.
   function automatic logic [SET_W-1:0] low_mask(input logic [ACT_W-1:0] n);
      logic [SET_W-1:0] m;
      if (n >= ACT_W'(SET_W)) begin
         m = '1;
      end else begin
         m = (SET_W'(1) << n) - SET_W'(1);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// ===== src/nss_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module nss_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 320
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/nss_merge.sv =====
// Applies one transition to the set being built during a pass.
// Depends on nss_pkg for the entry type and set width.
`timescale 1ns / 1ps
`default_nettype none

module nss_merge #(
   parameter int MAX_STATES = 64
) (
   input  wire logic                       entry_valid,
   input  wire nss_pkg::entry_type         entry,
   input  wire logic [nss_pkg::SET_W-1:0]  old_set,
   input  wire logic [nss_pkg::SET_W-1:0]  cur_set,
   output logic      [nss_pkg::SET_W-1:0]  new_set,
   output logic                            added
);

   logic in_range;

   always_comb begin
      in_range = ((nss_pkg::ACT_W)'(entry.src) < (nss_pkg::ACT_W)'(MAX_STATES)) &&
                 ((nss_pkg::ACT_W)'(entry.dst) < (nss_pkg::ACT_W)'(MAX_STATES));
      // A bit counts as added only if it was not already in the new set.
      added   = entry_valid && in_range && old_set[entry.src] && !cur_set[entry.dst];
      new_set = cur_set;
      if (added) begin
         new_set[entry.dst] = 1'b1;
      end
   end

endmodule

`default_nettype wire

// ===== src/nfa_state_set_step.sv =====
// Automaton state-set stepper on a table RAM; uses nss_pkg, nss_ram and nss_merge.
// Writes, set loads, unknown modes and bad symbols go straight from acceptance to the finish state.
// A symbol step walks the symbol's list one entry per cycle; a closure repeats passes over the
// epsilon list until a pass adds no state. One item is in work at a time; the next can be
// accepted in the same cycle that its result becomes valid. Synchronous active-high reset clears
// the set, the counts and the sequencer and sets the active state count to 64, not the table.
`timescale 1ns / 1ps
`default_nettype none

module nfa_state_set_step #(
   parameter int ALPHABET   = 4,
   parameter int MAX_STATES = 64,
   parameter int MAX_TRANS  = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Input item channel.
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [2:0]                        req_mode,
   input  wire logic [3:0]                        req_symbol,
   input  wire logic [5:0]                        req_entry_index,
   input  wire logic [nss_pkg::STATE_W-1:0]       req_source_state,
   input  wire logic [nss_pkg::STATE_W-1:0]       req_target_state,
   input  wire logic [6:0]                        req_list_count,
   input  wire logic [nss_pkg::SET_W-1:0]         req_state_set,
   // Result item channel.
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [nss_pkg::SET_W-1:0]         rsp_next_set,
   output logic                                   rsp_unchanged,
   output logic                                   rsp_range_error,
   // Configuration register write port.
   input  wire logic                              csr_write,
   input  wire logic [nss_pkg::ACT_W-1:0]         csr_active_states
);

   // Table geometry: one list of MAX_TRANS entries per symbol, epsilon first.
   localparam int SYMS      = ALPHABET + 1;
   localparam int SW        = $clog2(SYMS);
   localparam int TBL_DEPTH = SYMS * MAX_TRANS;
   localparam int AW        = $clog2(TBL_DEPTH);
   localparam int CW        = $clog2(MAX_TRANS + 1);
   localparam int XW        = 9;   // wide enough to compare any list index or count

   localparam logic [nss_pkg::SET_W-1:0] STATE_MASK =
      nss_pkg::low_mask((nss_pkg::ACT_W)'(MAX_STATES));

   // Sequencer and pass state.
   nss_pkg::state_type            state_ff, state_in;
   logic [nss_pkg::ACT_W-1:0]     active_ff;
   logic [nss_pkg::SET_W-1:0]     set_ff, set_in;
   logic [nss_pkg::SET_W-1:0]     old_ff, old_in;
   logic [AW-1:0]                 base_ff, base_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic [CW-1:0]                 rd_ff, rd_in;
   logic                          pend_ff, pend_in;
   logic                          added_ff, added_in;
   logic                          first_ff, first_in;
   logic                          closure_ff, closure_in;
   logic                          unch_ff, unch_in;
   logic                          err_ff, err_in;
   logic [CW-1:0]                 counts_ff [SYMS];

   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [nss_pkg::SET_W-1:0]     rsp_set_ff;
   logic                          rsp_unch_ff;
   logic                          rsp_err_ff;

   // Table port and counts write.
   logic                          tbl_we;
   logic [AW-1:0]                 tbl_waddr;
   nss_pkg::entry_type            tbl_wentry;
   logic                          tbl_re;
   logic [AW-1:0]                 tbl_raddr;
   logic [nss_pkg::ENTRY_W-1:0]   tbl_rdata;
   logic                          cnt_we;
   logic [SW-1:0]                 cnt_sel;
   logic [CW-1:0]                 cnt_val;

   logic                          accept;
   logic                          sym_ok;
   logic [SW-1:0]                 sym_sel;
   logic                          out_free;
   logic                          start_pass;
   logic [nss_pkg::ACT_W-1:0]     clear_n;
   logic [nss_pkg::SET_W-1:0]     merge_set;
   logic                          merge_added;

   assign req_stall       = (state_ff != nss_pkg::ST_IDLE);
   assign accept          = req_valid && !req_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_set    = rsp_set_ff;
   assign rsp_unchanged   = rsp_unch_ff;
   assign rsp_range_error = rsp_err_ff;
   assign out_free        = !rsp_valid_ff || !rsp_stall;

   assign sym_ok  = (req_symbol <= 4'(ALPHABET));
   assign clear_n = (active_ff > (nss_pkg::ACT_W)'(MAX_STATES)) ?
                    (nss_pkg::ACT_W)'(MAX_STATES) : active_ff;

   nss_ram #(
      .WIDTH (nss_pkg::ENTRY_W),
      .DEPTH (TBL_DEPTH)
   ) u_table (
      .clock      (clock),
      .wr_en      (tbl_we),
      .wr_addr    (tbl_waddr),
      .wr_data    (tbl_wentry),
      .rd_en      (tbl_re),
      .rd_addr    (tbl_raddr),
      .rd_data_ff (tbl_rdata)
   );

   // The entry read last cycle is folded into the set being built; sources are
   // always tested against the set as it stood when the pass began.
   nss_merge #(
      .MAX_STATES (MAX_STATES)
   ) u_merge (
      .entry_valid (pend_ff),
      .entry       (nss_pkg::entry_type'(tbl_rdata)),
      .old_set     (old_ff),
      .cur_set     (set_ff),
      .new_set     (merge_set),
      .added       (merge_added)
   );

   // Reads issue one per cycle while entries remain in the list.
   assign tbl_re    = (state_ff == nss_pkg::ST_RUN) && (rd_ff < cnt_ff);
   assign tbl_raddr = base_ff + AW'(rd_ff);

   always_comb begin
      state_in   = state_ff;
      set_in     = set_ff;
      old_in     = old_ff;
      base_in    = base_ff;
      cnt_in     = cnt_ff;
      rd_in      = rd_ff;
      pend_in    = 1'b0;
      added_in   = added_ff;
      first_in   = first_ff;
      closure_in = closure_ff;
      unch_in    = unch_ff;
      err_in     = err_ff;
      tbl_we     = 1'b0;
      tbl_waddr  = AW'(AW'(req_symbol[SW-1:0]) * AW'(MAX_TRANS) + AW'(req_entry_index));
      tbl_wentry = '{src: req_source_state, dst: req_target_state};
      cnt_we     = 1'b0;
      cnt_sel    = req_symbol[SW-1:0];
      cnt_val    = ({2'b00, req_list_count} > XW'(MAX_TRANS)) ?
                   CW'(MAX_TRANS) : CW'(req_list_count);
      start_pass = 1'b0;
      sym_sel    = req_symbol[SW-1:0];
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         nss_pkg::ST_IDLE: begin
            if (accept) begin
               unch_in    = 1'b1;
               err_in     = 1'b0;
               closure_in = 1'b0;
               state_in   = nss_pkg::ST_FIN;
               case (req_mode)
                  nss_pkg::MODE_WRITE_TRANS: begin
                     if (!sym_ok) begin
                        err_in = 1'b1;
                     end else if ({3'b000, req_entry_index} < XW'(MAX_TRANS)) begin
                        tbl_we = 1'b1;
                     end
                  end
                  nss_pkg::MODE_WRITE_COUNT: begin
                     if (!sym_ok) begin
                        err_in = 1'b1;
                     end else begin
                        cnt_we = 1'b1;
                     end
                  end
                  nss_pkg::MODE_LOAD_SET: begin
                     set_in = req_state_set & STATE_MASK;
                  end
                  nss_pkg::MODE_SYMBOL_STEP: begin
                     if (!sym_ok) begin
                        err_in = 1'b1;
                     end else begin
                        start_pass = 1'b1;
                     end
                  end
                  nss_pkg::MODE_CLOSURE: begin
                     start_pass = 1'b1;
                     closure_in = 1'b1;
                     sym_sel    = '0;
                  end
                  default: begin
                  end
               endcase
               if (start_pass) begin
                  state_in = nss_pkg::ST_RUN;
                  base_in  = AW'(AW'(sym_sel) * AW'(MAX_TRANS));
                  cnt_in   = counts_ff[sym_sel];
                  rd_in    = '0;
                  added_in = 1'b0;
                  first_in = 1'b1;
                  old_in   = set_ff;
                  // A letter clears the states in use; epsilon keeps the old set.
                  if (sym_sel == '0) begin
                     set_in = set_ff;
                  end else begin
                     set_in = set_ff & ~nss_pkg::low_mask(clear_n);
                  end
               end
            end
         end
         nss_pkg::ST_RUN: begin
            if (pend_ff) begin
               set_in   = merge_set;
               added_in = added_ff | merge_added;
            end
            if (tbl_re) begin
               rd_in   = rd_ff + CW'(1);
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               // Every entry of this pass has been merged.
               if (first_ff) begin
                  unch_in = !added_ff;
               end
               if (closure_ff && added_ff) begin
                  old_in   = set_ff;
                  rd_in    = '0;
                  added_in = 1'b0;
                  first_in = 1'b0;
               end else begin
                  state_in = nss_pkg::ST_FIN;
               end
            end
         end
         nss_pkg::ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = nss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nss_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nss_pkg::ST_IDLE;
         active_ff    <= (nss_pkg::ACT_W)'(64);
         set_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SYMS; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         set_ff       <= set_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            active_ff <= csr_active_states;
         end
         if (cnt_we) begin
            counts_ff[cnt_sel] <= cnt_val;
         end
      end
   end

   // Pass bookkeeping and result payload: no reset needed.
   always_ff @(posedge clock) begin
      old_ff     <= old_in;
      base_ff    <= base_in;
      cnt_ff     <= cnt_in;
      rd_ff      <= rd_in;
      added_ff   <= added_in;
      first_ff   <= first_in;
      closure_ff <= closure_in;
      unch_ff    <= unch_in;
      err_ff     <= err_in;
      if ((state_ff == nss_pkg::ST_FIN) && out_free) begin
         rsp_set_ff  <= set_ff;
         rsp_unch_ff <= unch_ff;
         rsp_err_ff  <= err_ff;
      end
   end

endmodule

`default_nettype wire
